// ===== rtl/vtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types, constants and register reset values for the vertex
// transform and projection pipeline.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int NREG              = 8;
    localparam int ADDR_W            = 6;
    localparam int SIZE_W            = 13;
    localparam int NUM_W             = 49;
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    // Status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SAT   = 2'd1;
    localparam t_status ST_WZERO = 2'd2;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic  func;
        t_word pos_x;
        t_word pos_y;
        t_word pos_z;
    } t_vtx_in;

    typedef struct packed {
        t_word   out_x;
        t_word   out_y;
        t_word   out_z;
        t_word   out_w;
        t_status status;
    } t_vtx_out;

    // Transform results handed to the divider
    typedef struct packed {
        logic  func;
        logic  sat;
        t_word x;
        t_word y;
        t_word z;
        t_word w;
    } t_xf;

    // Side data carried down the divider
    typedef struct packed {
        t_xf        xf;
        logic [2:0] neg;
    } t_dv;

    // Identity matrix after reset
    localparam logic [63:0] COEF_RST [NREG] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
    };

endpackage
`default_nettype wire

// ===== rtl/vtp_xform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_xform
// Row vector times 4x4 matrix: multiply stage, column sum stage, and
// round plus saturate stage.
// ----------------------------------------------------------------------------
module vtp_xform
    import vtp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_vtx_in           i_vtx,
    input  wire logic [NREG-1:0][63:0] i_coef,
    output logic                   o_valid,
    output t_xf                    o_xf
);

    logic signed [31:0] w_m   [4][4];
    logic signed [31:0] w_pos [3];

    logic signed [63:0] r_p   [4][3];
    logic signed [31:0] r_t   [4];
    logic               r_f1;
    logic signed [65:0] r_sum [4];
    logic               r_f2;
    logic signed [65:0] w_rnd [4];
    logic [3:0]         w_hi;
    logic [3:0]         w_lo;
    t_word              w_res [4];
    logic               r_v1, r_v2, r_v3;
    t_xf                r_xf;

    // Unpack the matrix words
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_m[r][c] = i_coef[3'(r * 2 + c / 2)][(c % 2) * 32 +: 32];
            end
        end
        w_pos[0] = i_vtx.pos_x;
        w_pos[1] = i_vtx.pos_y;
        w_pos[2] = i_vtx.pos_z;
    end

    // Stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_p[c][r] <= w_pos[r] * w_m[r][c];
                end
                r_t[c] <= w_m[3][c];
            end
            r_f1 <= i_vtx.func;
        end
    end

    // Stage 2: exact column sums, translation row weighted by one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= 66'(r_p[c][0]) + 66'(r_p[c][1]) + 66'(r_p[c][2])
                          + {{18{r_t[c][31]}}, r_t[c], 16'h0000};
            end
            r_f2 <= r_f1;
        end
    end

    // Stage 3: round half up to Q16.16 and clamp
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_rnd[c] = (r_sum[c] + 66'sd32768) >>> 16;
            w_hi[c]  = w_rnd[c] > 66'sd2147483647;
            w_lo[c]  = w_rnd[c] < -66'sd2147483648;
            if (w_hi[c]) begin
                w_res[c] = 32'sh7FFF_FFFF;
            end else if (w_lo[c]) begin
                w_res[c] = 32'sh8000_0000;
            end else begin
                w_res[c] = w_rnd[c][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xf.func <= r_f2;
            r_xf.sat  <= |(w_hi | w_lo);
            r_xf.x    <= w_res[0];
            r_xf.y    <= w_res[1];
            r_xf.z    <= w_res[2];
            r_xf.w    <= w_res[3];
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_xf    = r_xf;

endmodule
`default_nettype wire

// ===== rtl/vtp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// (x, y, z) sharing the divisor |w|. Rounds to nearest by adding |w|/2.
// ----------------------------------------------------------------------------
module vtp_div
    import vtp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire t_xf                   i_xf,
    output logic                       o_valid,
    output t_dv                        o_dv,
    output logic [2:0][NUM_W-1:0]      o_quo
);

    logic [NUM_W-1:0] r_num [NUM_W+1][3];
    logic [31:0]      r_rem [NUM_W+1][3];
    logic [31:0]      r_ud  [NUM_W+1];
    t_dv              r_sd  [NUM_W+1];
    logic             r_v   [NUM_W+1];

    t_word            w_n   [3];
    logic [31:0]      w_un  [3];
    logic [31:0]      w_ud;

    // Prepare magnitudes
    always_comb begin
        w_n[0] = i_xf.x;
        w_n[1] = i_xf.y;
        w_n[2] = i_xf.z;
        w_ud   = i_xf.w[31] ? (~i_xf.w + 32'd1) : i_xf.w;
        for (int i = 0; i < 3; i++) begin
            w_un[i] = w_n[i][31] ? (~w_n[i] + 32'd1) : w_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[0][i] <= {1'b0, w_un[i], 16'h0000} + NUM_W'(w_ud[31:1]);
                r_rem[0][i] <= '0;
                r_sd[0].neg[i] <= w_n[i][31] ^ i_xf.w[31];
            end
            r_ud[0]   <= w_ud;
            r_sd[0].xf <= i_xf;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [32:0] w_sh [3];
        logic [2:0]  w_ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_sh[i] = {r_rem[k][i], r_num[k][i][NUM_W-1]};
                w_ge[i] = w_sh[i] >= {1'b0, r_ud[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[k+1][i] <= w_ge[i] ? 32'(w_sh[i] - {1'b0, r_ud[k]})
                                             : w_sh[i][31:0];
                    r_num[k+1][i] <= {r_num[k][i][NUM_W-2:0], w_ge[i]};
                end
                r_ud[k+1] <= r_ud[k];
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < NUM_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid  = r_v[NUM_W];
    assign o_dv     = r_sd[NUM_W];
    assign o_quo[0] = r_num[NUM_W][0];
    assign o_quo[1] = r_num[NUM_W][1];
    assign o_quo[2] = r_num[NUM_W][2];

endmodule
`default_nettype wire

// ===== rtl/vtp_view.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_view
// Sign the quotients, map x and y to the viewport, clamp and pick the
// result for the requested function. Second stage is the output register.
// ----------------------------------------------------------------------------
module vtp_view
    import vtp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire t_dv                   i_dv,
    input  wire logic [2:0][NUM_W-1:0] i_quo,
    output logic                       o_valid,
    output t_vtx_out                   o_res
);

    localparam logic signed [SIZE_W:0] SW = (SIZE_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [SIZE_W:0] SH = (SIZE_W + 1)'(SCREEN_HEIGHT);

    logic signed [NUM_W:0]   w_q  [3];
    logic signed [NUM_W+1:0] w_qx1, w_qy1;

    logic signed [65:0]  r_vx, r_vy;
    logic signed [NUM_W:0] r_qz;
    t_xf                 r_xf;
    logic                r_va;

    logic signed [65:0]  w_hx, w_hy;
    logic                w_sx, w_sy, w_sz;
    t_word               w_ox, w_oy, w_oz;
    t_vtx_out            n_res;
    t_vtx_out            r_res;
    logic                r_vb;

    // Stage A: apply sign, add one and scale by the screen size
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i] = i_dv.neg[i] ? -$signed({1'b0, i_quo[i]}) : $signed({1'b0, i_quo[i]});
        end
        w_qx1 = (NUM_W + 2)'(w_q[0]) + (NUM_W + 2)'(65536);
        w_qy1 = (NUM_W + 2)'(w_q[1]) + (NUM_W + 2)'(65536);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx <= w_qx1 * SW;
            r_vy <= w_qy1 * SH;
            r_qz <= w_q[2];
            r_xf <= i_dv.xf;
        end
    end

    // Stage B: halve with half rounded up, clamp and select
    always_comb begin
        w_hx = (r_vx + 66'sd1) >>> 1;
        w_hy = (r_vy + 66'sd1) >>> 1;
        w_sx = (w_hx > 66'sd2147483647) || (w_hx < -66'sd2147483648);
        w_sy = (w_hy > 66'sd2147483647) || (w_hy < -66'sd2147483648);
        w_sz = (r_qz > (NUM_W + 1)'(64'sd2147483647))
            || (r_qz < -(NUM_W + 1)'(64'sd2147483648));
        w_ox = w_sx ? (w_hx[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_hx[31:0];
        w_oy = w_sy ? (w_hy[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_hy[31:0];
        w_oz = w_sz ? (r_qz[NUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : r_qz[31:0];

        n_res.out_w = r_xf.w;
        if (!r_xf.func) begin
            n_res.out_x  = r_xf.x;
            n_res.out_y  = r_xf.y;
            n_res.out_z  = r_xf.z;
            n_res.status = r_xf.sat ? ST_SAT : ST_OK;
        end else if (r_xf.w == '0) begin
            n_res.out_x  = '0;
            n_res.out_y  = '0;
            n_res.out_z  = '0;
            n_res.status = ST_WZERO;
        end else begin
            n_res.out_x  = w_ox;
            n_res.out_y  = w_oy;
            n_res.out_z  = w_oz;
            n_res.status = (r_xf.sat | w_sx | w_sy | w_sz) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign o_valid = r_vb;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ===== rtl/vertex_transform_project.sv =====
`default_nettype none
// Path from an accepted request to its result: 3 transform stages,
// 50 divider stages and 2 viewport stages.
// Throughput: one vertex per cycle; the whole pipeline holds while the
// output register is full and stalled.
// Reset: synchronous, active low; clears all valid bits and loads the
// identity matrix into the coefficient registers.
// ----------------------------------------------------------------------------
// vertex_transform_project
// Vertex transform by a 4x4 Q16.16 matrix with optional perspective
// divide and viewport map; APB coefficient registers.
// ----------------------------------------------------------------------------
module vertex_transform_project
    import vtp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_vtx_in           i_vtx,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_vtx_out               o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    logic [NREG-1:0][63:0] r_coef;
    logic [2:0]            w_idx;
    logic                  w_en;
    logic                  w_xv;
    t_xf                   w_xf;
    logic                  w_dv;
    t_dv                   w_dd;
    logic [2:0][NUM_W-1:0] w_quo;

    // Register file
    assign w_idx  = paddr[ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = r_coef[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NREG; i++) begin
                r_coef[i] <= COEF_RST[i];
            end
        end else if (psel && penable && pwrite) begin
            r_coef[w_idx] <= pwdata;
        end
    end

    // Hold every stage while the output request waits
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    vtp_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vtx   (i_vtx),
        .i_coef  (r_coef),
        .o_valid (w_xv),
        .o_xf    (w_xf)
    );

    vtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xv),
        .i_xf    (w_xf),
        .o_valid (w_dv),
        .o_dv    (w_dd),
        .o_quo   (w_quo)
    );

    vtp_view #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_dv    (w_dd),
        .i_quo   (w_quo),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
